// ----- design/fir_circ_pkg.sv -----
package fir_circ_pkg;

   // Store geometry
   localparam int MAX_TAPS       = 64;
   localparam int TAP_IDX_W      = $clog2(MAX_TAPS);
   localparam int TAP_CNT_W      = 7;

   // Field widths
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 18;
   localparam int COEF_FRAC_BITS = 16;

   // Datapath widths
   localparam int PROD_W         = SAMPLE_W + COEF_W;
   localparam int ACC_W          = PROD_W + TAP_IDX_W;
   localparam int QUOT_W         = ACC_W - COEF_FRAC_BITS;

   // Command codes
   localparam logic CMD_FILTER   = 1'b0;
   localparam logic CMD_LOAD     = 1'b1;

endpackage

// ----- design/fir_filter_circular.sv -----
// Direct-form FIR filter over a circular sample store. A request with cmd
// CMD_LOAD writes one Q2.16 coefficient and gives no response. A request
// with cmd CMD_FILTER stores the sample in the ring at its transfer and
// gives one filtered sample over m taps, m being the number of taps in use
// (1 to 64). A single shared multiply-accumulate, fed by the registered read
// ports of the coefficient and sample memories, takes one tap per cycle, m
// taps in all; each tap passes the read registers, the product register and
// the final sum. The input stays stalled from the transfer until the
// response is loaded, so the next sample waits until then. A response still
// waiting in the output register holds the next one in its final stage and
// keeps the input stalled longer. The response sits in an output register,
// so a new request is taken while the previous response still waits.
// Writing tap_count restarts warm-up; ring contents and coefficients are
// kept. Coefficients read as zero until loaded; no clearing pass is needed
// after reset.
module fir_filter_circular (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic signed [fir_circ_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic        [fir_circ_pkg::TAP_IDX_W-1:0] req_coef_index,
   input  logic signed [fir_circ_pkg::COEF_W-1:0]    req_coef_value,
   // Response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fir_circ_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                   rsp_saturated,
   // Tap count register
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [fir_circ_pkg::TAP_CNT_W-1:0] csr_tap_count
);
   import fir_circ_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN
   } state_type;

   state_type                   state_ff;
   logic [TAP_CNT_W-1:0]        tap_count_ff;
   logic [TAP_IDX_W-1:0]        wp_ff;
   logic                        full_ff;
   logic [TAP_CNT_W-1:0]        i_ff;
   logic [TAP_IDX_W-1:0]        k_ff;
   logic [TAP_CNT_W-1:0]        limit_ff;
   logic                        rd_vld_ff;
   logic                        mul_vld_ff;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                        rsp_sat_ff;

   logic signed [SAMPLE_W-1:0]  ring_mem [MAX_TAPS];
   logic signed [COEF_W-1:0]    coef_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]         coef_vld_ff;
   logic signed [SAMPLE_W-1:0]  ring_rd_ff;
   logic signed [COEF_W-1:0]    coef_rd_ff;
   logic                        coef_ok_ff;
   logic signed [PROD_W-1:0]    product_ff;
   logic signed [ACC_W-1:0]     acc_ff;

   logic                        req_accept;
   logic                        filter_accept;
   logic                        load_accept;
   logic                        csr_write;
   logic [TAP_CNT_W-1:0]        taps_m;
   logic [TAP_IDX_W-1:0]        wp_eff;
   logic [TAP_CNT_W-1:0]        wp_inc;
   logic                        wp_wrap;
   logic [TAP_IDX_W-1:0]        wp_in;
   logic                        full_in;
   logic [TAP_CNT_W-1:0]        i_inc;
   logic [TAP_CNT_W-1:0]        k_inc;
   logic [TAP_IDX_W-1:0]        k_in;
   logic signed [COEF_W-1:0]    coef_mul;
   logic signed [QUOT_W-1:0]    quot;
   logic                        quot_hi;
   logic                        quot_lo;
   logic                        pipe_empty;
   logic                        rsp_free;
   logic                        rsp_load;

   // Handshakes
   assign req_stall     = (state_ff != S_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign filter_accept = req_accept && (req_cmd == CMD_FILTER);
   assign load_accept   = req_accept && (req_cmd == CMD_LOAD);
   assign csr_ready     = 1'b1;
   assign csr_write     = csr_valid && csr_ready;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;

   // Clamp the tap count into range
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_m = TAP_CNT_W'(1);
      end else if (tap_count_ff > TAP_CNT_W'(MAX_TAPS)) begin
         taps_m = TAP_CNT_W'(MAX_TAPS);
      end else begin
         taps_m = tap_count_ff;
      end
   end

   // Advance the write pointer around the ring
   assign wp_eff  = ({1'b0, wp_ff} >= taps_m) ? '0 : wp_ff;
   assign wp_inc  = {1'b0, wp_eff} + TAP_CNT_W'(1);
   assign wp_wrap = (wp_inc >= taps_m);
   assign wp_in   = wp_wrap ? '0 : wp_inc[TAP_IDX_W-1:0];
   assign full_in = full_ff || wp_wrap;

   // Tap and ring index steps
   assign i_inc = i_ff + TAP_CNT_W'(1);
   assign k_inc = {1'b0, k_ff} + TAP_CNT_W'(1);
   assign k_in  = (k_inc == limit_ff) ? '0 : k_inc[TAP_IDX_W-1:0];

   // Drop the accumulator to the output scale and saturate
   assign quot       = acc_ff[ACC_W-1:COEF_FRAC_BITS];
   assign quot_hi    = !quot[QUOT_W-1] && (quot[QUOT_W-2:SAMPLE_W-1] != '0);
   assign quot_lo    = quot[QUOT_W-1] && (quot[QUOT_W-2:SAMPLE_W-1] != '1);
   assign pipe_empty = !rd_vld_ff && !mul_vld_ff;
   assign rsp_load   = (state_ff == S_DRAIN) && pipe_empty && rsp_free;

   // Control sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_count_ff <= TAP_CNT_W'(1);
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         limit_ff     <= TAP_CNT_W'(1);
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= (state_ff == S_MAC);
         mul_vld_ff <= rd_vld_ff;
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            tap_count_ff <= csr_tap_count;
            wp_ff        <= '0;
            full_ff      <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (filter_accept) begin
                  wp_ff    <= wp_in;
                  full_ff  <= full_in;
                  i_ff     <= '0;
                  k_ff     <= full_in ? wp_in : '0;
                  limit_ff <= full_in ? taps_m : {1'b0, wp_in};
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               i_ff <= i_inc;
               k_ff <= k_in;
               if (i_inc == taps_m) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (rsp_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sat_ff    <= quot_hi || quot_lo;
                  if (quot_hi) begin
                     rsp_sample_ff <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                  end else if (quot_lo) begin
                     rsp_sample_ff <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                  end else begin
                     rsp_sample_ff <= quot[SAMPLE_W-1:0];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Sample ring: store on transfer, read one tap per cycle
   always_ff @(posedge clock) begin
      if (filter_accept) begin
         ring_mem[wp_eff] <= req_sample_in;
      end
      ring_rd_ff <= ring_mem[k_ff];
   end

   // Coefficient store: load on transfer, read one tap per cycle
   always_ff @(posedge clock) begin
      if (load_accept) begin
         coef_mem[req_coef_index] <= req_coef_value;
      end
      coef_rd_ff <= coef_mem[i_ff[TAP_IDX_W-1:0]];
   end

   // Coefficient loaded flags; an unloaded entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         coef_ok_ff  <= 1'b0;
      end else begin
         if (load_accept) begin
            coef_vld_ff[req_coef_index] <= 1'b1;
         end
         coef_ok_ff <= coef_vld_ff[i_ff[TAP_IDX_W-1:0]];
      end
   end

   assign coef_mul = coef_ok_ff ? coef_rd_ff : '0;

   // Multiply, then accumulate
   always_ff @(posedge clock) begin
      product_ff <= coef_mul * ring_rd_ff;
      if (filter_accept) begin
         acc_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(product_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
